@@ sv/pms_pkg.sv @@
package pms_pkg;

  localparam int TOTAL_DEPTH = 16;
  localparam int NUM_STACKS  = 4;
  localparam int NUM_CFG     = 4;

  localparam int DATA_W    = 32;
  localparam int SIZE_W    = 5;
  localparam int SID_W     = 2;
  localparam int CMD_W     = 1;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int ADDR_W    = $clog2(TOTAL_DEPTH);
  localparam int SEL_W     = $clog2(NUM_STACKS);
  localparam int SIZE_MAX  = (1 << SIZE_W) - 1;
  localparam int SUM_W     = $clog2(NUM_STACKS * SIZE_MAX + TOTAL_DEPTH + 1);

  localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(4);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic load_in;
    logic calc;
    logic mem;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

@@ sv/pms_in_if.sv @@
interface pms_in_if;
  import pms_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic [SID_W-1:0]         stack_id;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, output cmd, output stack_id, output push_value,
                  input ready);
  modport sink   (input valid, input cmd, input stack_id, input push_value,
                  output ready);
endinterface

@@ sv/pms_out_if.sv @@
interface pms_out_if;
  import pms_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] pop_value;
  logic [SIZE_W-1:0]        fill_after;

  modport source (output valid, output status, output pop_value, output fill_after,
                  input ready);
  modport sink   (input valid, input status, input pop_value, input fill_after,
                  output ready);
endinterface

@@ sv/pms_ctrl.sv @@
module pms_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pms_pkg::dp_stat_t stat,
  output pms_pkg::dp_cmd_t  cmd
);
  import pms_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CALC = 4'b0010,
    S_MEM  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_MEM;
      end
      S_MEM: begin
        cmd.mem   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_CALC))
    else $error("accepted transaction did not start calculation");

  a_calc_to_mem: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.calc |=> cmd.mem)
    else $error("calculation not followed by memory access");

  a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> in_ready)
    else $error("controller did not return to idle after result load");
`endif

endmodule

@@ sv/pms_dp.sv @@
module pms_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pms_pkg::dp_cmd_t                 cmd,
  output pms_pkg::dp_stat_t                stat,
  input  logic [pms_pkg::CMD_W-1:0]        in_cmd,
  input  logic [pms_pkg::SID_W-1:0]        in_stack_id,
  input  logic signed [pms_pkg::DATA_W-1:0] in_push_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [pms_pkg::STATUS_W-1:0]     out_status,
  output logic signed [pms_pkg::DATA_W-1:0] out_pop_value,
  output logic [pms_pkg::SIZE_W-1:0]       out_fill_after,
  input  logic                             cfg_we,
  input  logic [pms_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pms_pkg::SIZE_W-1:0]       cfg_wdata
);
  import pms_pkg::*;

  logic [SIZE_W-1:0] size_r [NUM_STACKS];
  logic [SIZE_W-1:0] fill_cnt_r [NUM_STACKS];
  logic [DATA_W-1:0] mem [TOTAL_DEPTH];

  logic              is_pop_r;
  logic [SID_W-1:0]  sid_r;
  logic [DATA_W-1:0] val_r;

  status_t           status_r;
  logic [SIZE_W-1:0] fill_new_r;
  logic [ADDR_W-1:0] addr_r;
  logic [SEL_W-1:0]  sel_r;
  logic              sid_ok_r;
  logic [DATA_W-1:0] rdata_r;

  logic                 out_valid_r;
  status_t              out_status_r;
  logic [DATA_W-1:0]    out_pop_value_r;
  logic [SIZE_W-1:0]    out_fill_r;

  logic              sid_ok;
  logic [SEL_W-1:0]  sel;
  logic [SUM_W-1:0]  base;
  logic [SUM_W-1:0]  room;
  logic [SIZE_W-1:0] cap;
  logic [SIZE_W-1:0] fill_cur;
  logic [SIZE_W-1:0] fill_new;
  logic [SIZE_W-1:0] offset;
  status_t           status;

  always_comb begin
    sid_ok = (int'(sid_r) < NUM_STACKS);
    sel    = SEL_W'(sid_r);
    base   = '0;
    for (int i = 0; i < NUM_STACKS; i++) begin
      if (i < int'(sid_r)) begin
        base = base + SUM_W'(size_r[i]);
      end
    end
    room = (base < SUM_W'(TOTAL_DEPTH)) ? (SUM_W'(TOTAL_DEPTH) - base) : '0;
    cap  = (SUM_W'(size_r[sel]) < room) ? size_r[sel] : SIZE_W'(room);
    fill_cur = (fill_cnt_r[sel] > cap) ? cap : fill_cnt_r[sel];
    fill_new = fill_cur;
    offset   = fill_cur;
    status   = ST_OK;
    if (!sid_ok) begin
      status   = is_pop_r ? ST_EMPTY : ST_FULL;
      fill_new = '0;
    end else if (!is_pop_r) begin
      if (fill_cur >= cap) begin
        status = ST_FULL;
      end else begin
        fill_new = fill_cur + SIZE_W'(1);
      end
    end else begin
      if (fill_cur == '0) begin
        status = ST_EMPTY;
      end else begin
        fill_new = fill_cur - SIZE_W'(1);
        offset   = fill_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        size_r[i]     <= SIZE_RST;
        fill_cnt_r[i] <= '0;
      end
    end else begin
      if (cfg_we && (int'(cfg_index) < NUM_CFG) && (int'(cfg_index) < NUM_STACKS)) begin
        size_r[SEL_W'(cfg_index)] <= cfg_wdata;
      end
      if (cmd.mem && sid_ok_r) begin
        fill_cnt_r[sel_r] <= fill_new_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      is_pop_r <= (cmd_t'(in_cmd) == CMD_POP);
      sid_r    <= in_stack_id;
      val_r    <= in_push_value;
    end
    if (cmd.calc) begin
      status_r   <= status;
      fill_new_r <= fill_new;
      addr_r     <= ADDR_W'(base + SUM_W'(offset));
      sel_r      <= sel;
      sid_ok_r   <= sid_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem) begin
      if (!is_pop_r && (status_r == ST_OK)) begin
        mem[addr_r] <= val_r;
      end
      rdata_r <= mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r    <= status_r;
      out_pop_value_r <= (is_pop_r && (status_r == ST_OK)) ? rdata_r : '0;
      out_fill_r      <= fill_new_r;
    end
  end

  assign stat.out_free  = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_pop_value  = out_pop_value_r;
  assign out_fill_after = out_fill_r;

`ifndef SYNTHESIS
  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("result register not marked valid after load");

  a_pop_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.calc && is_pop_r && (status == ST_OK) |-> (fill_cur != '0))
    else $error("successful pop on an empty stack");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.calc |-> (fill_new <= cap))
    else $error("fill count beyond partition capacity");
`endif

endmodule

@@ sv/partitioned_multi_stack.sv @@
// Channel   Dir  Fields                             Handshake
// in_ch     in   cmd, stack_id, push_value          valid/ready
// out_ch    out  status, pop_value, fill_after      valid/ready
// cfg_*     in   cfg_index, cfg_wdata               cfg_we, no wait
//
// One transaction at a time, through accept, partition base/capacity sum, memory access
// with registered read and result load; a new one is accepted only after the result load.
// Synchronous active-low reset clears fill counts and sets all sizes to 4; the stack
// memory needs no clearing pass.
// A stalled result holds in the output register; a new transaction is taken while it
// waits, and its own result waits until the register frees.
module partitioned_multi_stack (
  input  logic                          clk,
  input  logic                          rst_n,
  pms_in_if.sink                        in_ch,
  pms_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [pms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pms_pkg::SIZE_W-1:0]    cfg_wdata
);
  import pms_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  pms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  pms_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (dp_cmd),
    .stat           (dp_stat),
    .in_cmd         (in_ch.cmd),
    .in_stack_id    (in_ch.stack_id),
    .in_push_value  (in_ch.push_value),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_status     (out_ch.status),
    .out_pop_value  (out_ch.pop_value),
    .out_fill_after (out_ch.fill_after),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

endmodule
